// ===== rtl/scs_pkg.sv =====
// Shared definitions for the static loop chunk splitter.
// Default parameter values and the chunk-mode encoding; no dependencies.
package scs_pkg;

  localparam int unsigned MaxThreadsDef = 1024;
  localparam int unsigned IterBitsDef   = 31;

  // How a request is answered, decided at the decode stage.
  typedef enum logic [1:0] {
    MODE_ONE,    // single thread owns everything
    MODE_SMALL,  // no more iterations than threads
    MODE_OVER,   // thread index past the thread count
    MODE_SPLIT   // even split with remainder
  } scs_mode_e;

endpackage

// ===== rtl/scs_div_stage.sv =====
// One registered step of the restoring divider: one quotient bit per stage.
// Uses scs_pkg; instantiated in a chain by the top level.
module scs_div_stage
  import scs_pkg::*;
#(
  parameter int unsigned ITER_BITS = IterBitsDef,
  parameter int unsigned THR_W     = 11,
  parameter int unsigned SIDE_W    = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic [THR_W-1:0]     n_i,
  input  logic                 valid_i,
  input  logic [THR_W-1:0]     rem_i,
  input  logic [ITER_BITS-1:0] quot_i,
  input  logic [ITER_BITS-1:0] dvd_i,
  input  logic [SIDE_W-1:0]    side_i,
  output logic                 valid_o,
  output logic [THR_W-1:0]     rem_o,
  output logic [ITER_BITS-1:0] quot_o,
  output logic [ITER_BITS-1:0] dvd_o,
  output logic [SIDE_W-1:0]    side_o
);

  logic [THR_W:0]   trial;
  logic             ge;
  logic [THR_W-1:0] rem_d;
  logic             valid_q;
  logic [THR_W-1:0] rem_q;
  logic [ITER_BITS-1:0] quot_q;
  logic [ITER_BITS-1:0] dvd_q;
  logic [SIDE_W-1:0]    side_q;

  // bring down the next dividend bit, subtract if it fits
  assign trial = {rem_i, dvd_i[ITER_BITS-1]};
  assign ge    = (trial >= {1'b0, n_i});
  always_comb begin
    if (ge) begin
      rem_d = THR_W'(trial - {1'b0, n_i});
    end else begin
      rem_d = THR_W'(trial);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      quot_q <= {quot_i[ITER_BITS-2:0], ge};
      dvd_q  <= {dvd_i[ITER_BITS-2:0], 1'b0};
      side_q <= side_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign quot_o  = quot_q;
  assign dvd_o   = dvd_q;
  assign side_o  = side_q;

endmodule

// ===== rtl/scs_chunk.sv =====
// Chunk bound computation: multiply stage, then add/select into the output register.
// Uses scs_pkg (scs_mode_e); fed by the divider chain.
module scs_chunk
  import scs_pkg::*;
#(
  parameter int unsigned ITER_BITS = IterBitsDef,
  parameter int unsigned TID_W     = 10,
  parameter int unsigned THR_W     = 11
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  scs_mode_e            mode_i,
  input  logic                 hit_i,
  input  logic [TID_W-1:0]     tid_i,
  input  logic [ITER_BITS-1:0] iters_i,
  input  logic [ITER_BITS-1:0] quot_i,
  input  logic [THR_W-1:0]     rem_i,
  output logic                 valid_o,
  output logic [ITER_BITS-1:0] first_o,
  output logic [ITER_BITS-1:0] end_o,
  output logic                 nonempty_o
);

  localparam int unsigned PROD_W = TID_W + ITER_BITS;
  localparam int unsigned WIDE   = ((ITER_BITS > TID_W) ? ITER_BITS : TID_W) + 1;

  logic [PROD_W-1:0] prod_full;
  logic              lt;

  logic                 a_valid_q;
  scs_mode_e            a_mode_q;
  logic                 a_hit_q;
  logic [TID_W-1:0]     a_tid_q;
  logic [ITER_BITS-1:0] a_iters_q;
  logic [ITER_BITS-1:0] a_prod_q;
  logic [THR_W-1:0]     a_minr_q;
  logic [ITER_BITS-1:0] a_qx_q;

  logic [ITER_BITS-1:0] split_first;
  logic [ITER_BITS-1:0] first_d;
  logic [ITER_BITS-1:0] end_d;
  logic                 ne_d;

  logic                 valid_q;
  logic [ITER_BITS-1:0] first_q;
  logic [ITER_BITS-1:0] end_q;
  logic                 ne_q;

  // first = tid*q + min(tid, r); length = q + (tid < r)
  assign prod_full = PROD_W'(tid_i) * PROD_W'(quot_i);
  assign lt        = (THR_W'(tid_i) < rem_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      valid_q   <= 1'b0;
    end else if (en_i) begin
      a_valid_q <= valid_i;
      valid_q   <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_mode_q  <= mode_i;
      a_hit_q   <= hit_i;
      a_tid_q   <= tid_i;
      a_iters_q <= iters_i;
      a_prod_q  <= prod_full[ITER_BITS-1:0];
      a_minr_q  <= lt ? THR_W'(tid_i) : rem_i;
      a_qx_q    <= quot_i + ITER_BITS'(lt);
    end
  end

  assign split_first = a_prod_q + ITER_BITS'(a_minr_q);

  always_comb begin
    case (a_mode_q)
      MODE_ONE: begin
        first_d = '0;
        end_d   = a_iters_q;
        ne_d    = (a_iters_q != '0);
      end
      MODE_SMALL: begin
        first_d = ITER_BITS'(a_tid_q);
        end_d   = ITER_BITS'(WIDE'(a_tid_q) + WIDE'(a_hit_q));
        ne_d    = a_hit_q;
      end
      MODE_OVER: begin
        first_d = a_iters_q;
        end_d   = a_iters_q;
        ne_d    = 1'b0;
      end
      MODE_SPLIT: begin
        first_d = split_first;
        end_d   = split_first + a_qx_q;
        ne_d    = (a_qx_q != '0);
      end
      default: begin
        first_d = '0;
        end_d   = '0;
        ne_d    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      first_q <= first_d;
      end_q   <= end_d;
      ne_q    <= ne_d;
    end
  end

  assign valid_o    = valid_q;
  assign first_o    = first_q;
  assign end_o      = end_q;
  assign nonempty_o = ne_q;

endmodule

// ===== rtl/static_loop_chunk_split.sv =====
// Top level of the static loop chunk splitter (block partition of a loop among threads).
// Uses scs_pkg, scs_div_stage and scs_chunk.
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+--------------------------------
//   in       | sink      | in_valid_i / in_stall_o | iter_count_i, thread_id_i
//   out      | source    | out_valid_o/out_stall_i | first_iter_o, end_iter_o, nonempty_o
//   cfg      | sink      | cfg_we_i                | cfg_wdata_i (num_threads)
//
// Throughput is one transaction per cycle unless the output stalls. The pipeline has
// one decode stage, one restoring-divider stage per quotient bit, a multiply stage and an
// add/select stage that is also the output register.
// Reset empties the pipeline and sets the thread count to 1.
// A stalled result freezes the whole pipeline (one shared enable); nothing is lost or repeated.
module static_loop_chunk_split
  import scs_pkg::*;
#(
  parameter int unsigned MAX_THREADS = MaxThreadsDef,
  parameter int unsigned ITER_BITS   = IterBitsDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration
  input  logic                                 cfg_we_i,
  input  logic [$clog2(MAX_THREADS+1)-1:0]     cfg_wdata_i,
  // request channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [ITER_BITS-1:0]                 iter_count_i,
  input  logic [$clog2(MAX_THREADS)-1:0]       thread_id_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [ITER_BITS-1:0]                 first_iter_o,
  output logic [ITER_BITS-1:0]                 end_iter_o,
  output logic                                 nonempty_o
);

  localparam int unsigned THR_W  = $clog2(MAX_THREADS + 1);
  localparam int unsigned TID_W  = $clog2(MAX_THREADS);
  localparam int unsigned WIDE   = ((ITER_BITS > THR_W) ? ITER_BITS : THR_W) + 1;
  // side payload carried along the divider: mode, hit, thread id, iteration count
  localparam int unsigned SIDE_W = 2 + 1 + TID_W + ITER_BITS;
  localparam int unsigned NDIV   = ITER_BITS;

  // ---------------------------------------------------------------------------
  // Thread count register. Saturated on write, so zero becomes 1 and anything
  // above MAX_THREADS becomes MAX_THREADS; the datapath only ever sees 1..MAX.
  // ---------------------------------------------------------------------------
  logic [THR_W-1:0] num_threads_d;
  logic [THR_W-1:0] num_threads_q;

  always_comb begin
    if (cfg_wdata_i == '0) begin
      num_threads_d = THR_W'(1);
    end else if (cfg_wdata_i > THR_W'(MAX_THREADS)) begin
      num_threads_d = THR_W'(MAX_THREADS);
    end else begin
      num_threads_d = cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_threads_q <= THR_W'(1);
    end else if (cfg_we_i) begin
      num_threads_q <= num_threads_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline enable: everything advances unless a finished result is held.
  // ---------------------------------------------------------------------------
  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  // ---------------------------------------------------------------------------
  // Decode stage: classify the request once so later stages just select.
  // ---------------------------------------------------------------------------
  scs_mode_e            mode_d;
  logic                 hit_d;
  logic                 s0_valid_q;
  logic [ITER_BITS-1:0] s0_iters_q;
  logic [SIDE_W-1:0]    s0_side_q;

  always_comb begin
    // tid < iters, only used when iters <= n
    hit_d = (WIDE'(thread_id_i) < WIDE'(iter_count_i));
    if (num_threads_q == THR_W'(1)) begin
      mode_d = MODE_ONE;
    end else if (WIDE'(iter_count_i) <= WIDE'(num_threads_q)) begin
      mode_d = MODE_SMALL;
    end else if (THR_W'(thread_id_i) >= num_threads_q) begin
      mode_d = MODE_OVER;
    end else begin
      mode_d = MODE_SPLIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (en) begin
      s0_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_iters_q <= iter_count_i;
      s0_side_q  <= {mode_d, hit_d, thread_id_i, iter_count_i};
    end
  end

  // ---------------------------------------------------------------------------
  // Divider chain: iters / n, MSB first, one quotient bit per stage.
  // ---------------------------------------------------------------------------
  logic [NDIV:0]                 dv_valid;
  logic [NDIV:0][THR_W-1:0]      dv_rem;
  logic [NDIV:0][ITER_BITS-1:0]  dv_quot;
  logic [NDIV:0][ITER_BITS-1:0]  dv_dvd;
  logic [NDIV:0][SIDE_W-1:0]     dv_side;

  assign dv_valid[0] = s0_valid_q;
  assign dv_rem[0]   = '0;
  assign dv_quot[0]  = '0;
  assign dv_dvd[0]   = s0_iters_q;
  assign dv_side[0]  = s0_side_q;

  for (genvar k = 0; k < NDIV; k++) begin : g_div
    scs_div_stage #(
      .ITER_BITS (ITER_BITS),
      .THR_W     (THR_W),
      .SIDE_W    (SIDE_W)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .n_i     (num_threads_q),
      .valid_i (dv_valid[k]),
      .rem_i   (dv_rem[k]),
      .quot_i  (dv_quot[k]),
      .dvd_i   (dv_dvd[k]),
      .side_i  (dv_side[k]),
      .valid_o (dv_valid[k+1]),
      .rem_o   (dv_rem[k+1]),
      .quot_o  (dv_quot[k+1]),
      .dvd_o   (dv_dvd[k+1]),
      .side_o  (dv_side[k+1])
    );
  end

  // unpack side payload at the divider output
  logic [SIDE_W-1:0]    side_end;
  scs_mode_e            dv_mode;
  logic                 dv_hit;
  logic [TID_W-1:0]     dv_tid;
  logic [ITER_BITS-1:0] dv_iters;

  assign side_end = dv_side[NDIV];
  assign dv_mode  = scs_mode_e'(side_end[SIDE_W-1 -: 2]);
  assign dv_hit   = side_end[SIDE_W-3];
  assign dv_tid   = side_end[ITER_BITS +: TID_W];
  assign dv_iters = side_end[ITER_BITS-1:0];

  // ---------------------------------------------------------------------------
  // Chunk bounds: multiply, then add/select into the output register.
  // ---------------------------------------------------------------------------
  scs_chunk #(
    .ITER_BITS (ITER_BITS),
    .TID_W     (TID_W),
    .THR_W     (THR_W)
  ) u_chunk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (dv_valid[NDIV]),
    .mode_i     (dv_mode),
    .hit_i      (dv_hit),
    .tid_i      (dv_tid),
    .iters_i    (dv_iters),
    .quot_i     (dv_quot[NDIV]),
    .rem_i      (dv_rem[NDIV]),
    .valid_o    (out_valid_o),
    .first_o    (first_iter_o),
    .end_o      (end_iter_o),
    .nonempty_o (nonempty_o)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_nthr_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (num_threads_q != '0) && (num_threads_q <= THR_W'(MAX_THREADS)))
    else $error("thread count register out of range");

  a_freeze : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("pipeline not frozen while result is held");

  a_div_rem : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_valid[NDIV] |-> (dv_rem[NDIV] < num_threads_q))
    else $error("divider remainder not below divisor");

  a_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (nonempty_o == (first_iter_o != end_iter_o)))
    else $error("nonempty flag disagrees with chunk bounds");

endmodule
